/* rtl/smf_pkg.sv */
// Shared types and constants of the substring match finder.
package smf_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int TEXT_MAX_DEF    = 4096;
    localparam int MATCH_MAX_DEF   = 128;
    localparam int QUEUE_DEPTH     = 4;

    localparam int PAT_W   = 64;
    localparam int LEN_W   = 4;
    localparam int IDX_W   = 12;
    localparam int TOTAL_W = 8;
    localparam int CFG_W   = 64;
    localparam int CFG_A_W = 1;

    // register indexes on the write port
    localparam logic [CFG_A_W-1:0] CFG_PATTERN_BYTES  = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

    // result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_text_item;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   match_start;
        logic [TOTAL_W-1:0] match_total;
        logic               found;
        logic               truncated;
        logic               last;
    } t_result;

    // one classified text request, waiting for the back end
    typedef struct packed {
        logic               has_match;
        logic               has_summary;
        logic [IDX_W-1:0]   m_start;
        logic [TOTAL_W-1:0] m_total;
        logic               m_trunc;
        logic [TOTAL_W-1:0] s_total;
        logic               s_found;
        logic               s_trunc;
    } t_entry;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } t_back_state;

endpackage

/* rtl/smf_front.sv */
// Front end: configuration registers, shift window compare and per-text state.
module smf_front #(
    parameter int PATTERN_MAX = smf_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = smf_pkg::TEXT_MAX_DEF,
    parameter int MATCH_MAX   = smf_pkg::MATCH_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [smf_pkg::CFG_A_W-1:0]   i_cfg_idx,
    input  logic [smf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  smf_pkg::t_text_item           i_item,
    output logic                          o_push,
    output smf_pkg::t_entry               o_entry
);

    localparam int RW  = ((PATTERN_MAX > 1) ? (PATTERN_MAX - 1) : 1) * 8;
    localparam int FW  = RW + 8;
    localparam int PW  = $clog2(TEXT_MAX + 1);
    localparam int PWX = (PW > smf_pkg::IDX_W) ? PW : smf_pkg::IDX_W;
    localparam int CW  = $clog2(MATCH_MAX + 1);
    localparam int CWX = (CW > smf_pkg::TOTAL_W) ? CW : smf_pkg::TOTAL_W;

    logic [smf_pkg::PAT_W-1:0] r_pat;
    logic [smf_pkg::LEN_W-1:0] r_len;
    logic [RW-1:0]             r_win,  n_win;
    logic [PW-1:0]             r_pos,  n_pos;
    logic [CW-1:0]             r_cnt,  n_cnt;
    logic                      r_drop, n_drop;

    logic [FW-1:0] full_win;
    logic          text_full;
    logic [PW-1:0] pos_inc;
    logic          len_ok;
    logic          sel_hit;
    logic          hit;
    logic          report;
    logic [CW-1:0] cnt_new;
    logic          drop_new;
    logic [PW-1:0] start_pos;
    logic [PWX-1:0] start_ext;
    logic [CWX-1:0] cnt_ext;
    logic [PATTERN_MAX:1] len_hit;

    assign full_win  = {r_win, i_item.text_byte};
    assign text_full = (r_pos >= PW'(TEXT_MAX));
    assign pos_inc   = r_pos + PW'(1);
    assign len_ok    = (r_len != '0) && (r_len <= smf_pkg::LEN_W'(PATTERN_MAX))
                       && (pos_inc >= PW'(r_len));

    // one comparator row per pattern length; newest byte sits at the bottom
    always_comb begin
        len_hit = '1;
        sel_hit = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (i < l) begin
                    if (full_win[(l-1-i)*8 +: 8] != r_pat[i*8 +: 8]) begin
                        len_hit[l] = 1'b0;
                    end
                end
            end
            if (r_len == smf_pkg::LEN_W'(l)) begin
                sel_hit = len_hit[l];
            end
        end
    end

    assign hit       = !text_full && len_ok && sel_hit;
    assign report    = hit && (r_cnt < CW'(MATCH_MAX));
    assign cnt_new   = r_cnt + CW'(report);
    assign drop_new  = r_drop || text_full || (hit && !report);
    assign start_pos = pos_inc - PW'(r_len);
    assign start_ext = PWX'(start_pos);
    assign cnt_ext   = CWX'(cnt_new);

    always_comb begin
        o_entry             = '0;
        o_entry.has_match   = report;
        o_entry.has_summary = i_item.end_of_text;
        o_entry.m_start     = start_ext[smf_pkg::IDX_W-1:0];
        o_entry.m_total     = cnt_ext[smf_pkg::TOTAL_W-1:0];
        o_entry.m_trunc     = r_drop;
        o_entry.s_total     = cnt_ext[smf_pkg::TOTAL_W-1:0];
        o_entry.s_found     = (cnt_new != '0);
        o_entry.s_trunc     = drop_new;
    end

    assign o_push = i_accept && (report || i_item.end_of_text);

    always_comb begin
        n_win  = r_win;
        n_pos  = r_pos;
        n_cnt  = r_cnt;
        n_drop = r_drop;
        if (i_accept) begin
            if (i_item.end_of_text) begin
                n_win  = '0;
                n_pos  = '0;
                n_cnt  = '0;
                n_drop = 1'b0;
            end else if (text_full) begin
                n_drop = 1'b1;
            end else begin
                n_win  = full_win[RW-1:0];
                n_pos  = pos_inc;
                n_cnt  = cnt_new;
                n_drop = drop_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_len  <= '0;
            r_win  <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
            r_drop <= 1'b0;
        end else begin
            r_win  <= n_win;
            r_pos  <= n_pos;
            r_cnt  <= n_cnt;
            r_drop <= n_drop;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    smf_pkg::CFG_PATTERN_BYTES:  r_pat <= i_cfg_data;
                    smf_pkg::CFG_PATTERN_LENGTH: r_len <= i_cfg_data[smf_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* rtl/smf_queue.sv */
// Short register queue of classified requests between front and back end.
module smf_queue #(
    parameter int DEPTH = smf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  smf_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output smf_pkg::t_entry o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    smf_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [NW-1:0]   r_num, n_num;
    logic            do_push, do_pop;

    assign o_full  = (r_num == NW'(DEPTH));
    assign o_empty = (r_num == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_num = r_num;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_num = r_num + NW'(1);
        end else if (do_pop && !do_push) begin
            n_num = r_num - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_num <= n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* rtl/smf_back.sv */
// Back end: expands a queued request into one or two results, output register.
module smf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  smf_pkg::t_entry i_head,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output smf_pkg::t_result o_result
);

    smf_pkg::t_back_state r_state, n_state;
    smf_pkg::t_result     r_out, n_out;
    logic                 r_valid, n_valid;
    logic                 load;
    logic                 sel_summary;

    assign load = !i_q_empty && (!r_valid || i_pop);

    // next state: only a request with both a match and a summary takes two turns
    always_comb begin
        n_state = r_state;
        if (load) begin
            unique case (r_state)
                smf_pkg::BK_FIRST:
                    n_state = (i_head.has_match && i_head.has_summary) ?
                              smf_pkg::BK_SECOND : smf_pkg::BK_FIRST;
                smf_pkg::BK_SECOND:
                    n_state = smf_pkg::BK_FIRST;
                default:
                    n_state = smf_pkg::BK_FIRST;
            endcase
        end
    end

    always_comb begin
        sel_summary = (r_state == smf_pkg::BK_SECOND) || !i_head.has_match;
        o_q_pop     = load && (sel_summary || !i_head.has_summary);
        n_out       = r_out;
        if (load) begin
            if (sel_summary) begin
                n_out.kind        = smf_pkg::KIND_SUMMARY;
                n_out.match_start = '0;
                n_out.match_total = i_head.s_total;
                n_out.found       = i_head.s_found;
                n_out.truncated   = i_head.s_trunc;
                n_out.last        = 1'b1;
            end else begin
                n_out.kind        = smf_pkg::KIND_MATCH;
                n_out.match_start = i_head.m_start;
                n_out.match_total = i_head.m_total;
                n_out.found       = 1'b1;
                n_out.truncated   = i_head.m_trunc;
                n_out.last        = 1'b0;
            end
        end
        if (load) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smf_pkg::BK_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty  = !r_valid;
    assign o_result = r_out;

endmodule

/* rtl/substring_match_finder.sv */
// Top level of the streaming substring match finder.
//
// Streaming substring search over a text given one byte per request. The
// pattern (up to PATTERN_MAX bytes, first byte in bits 7:0) and its length
// are written on the configuration port while the block is idle; a length of
// zero or above PATTERN_MAX never matches. Each text byte is compared, in
// the same cycle it is taken, against the last pattern-length bytes of a
// shift window, so a new byte is taken every cycle while the request queue
// has room: one byte per cycle sustained. Every match (overlaps included)
// gives a match report with its start index; the byte flagged end_of_text
// gives a summary with the count, found and truncated flags, and then clears
// the per-text state. A byte that both matches and ends the text gives two
// results, and the result side hands out one result per cycle while it is
// not stalled, so such a byte occupies it for both; the four-deep request
// queue between the compare front end and the result back end soaks that
// up. A result passes through the request queue and then the output
// register before it appears on o_result. Counts saturate at MATCH_MAX and
// bytes beyond TEXT_MAX are ignored; both set the truncated flag.
module substring_match_finder #(
    parameter int PATTERN_MAX = smf_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = smf_pkg::TEXT_MAX_DEF,
    parameter int MATCH_MAX   = smf_pkg::MATCH_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [smf_pkg::CFG_A_W-1:0] i_cfg_idx,
    input  logic [smf_pkg::CFG_W-1:0]   i_cfg_data,
    // text side
    input  logic                        push,
    output logic                        full,
    input  smf_pkg::t_text_item         i_text_item,
    // result side
    output logic                        empty,
    input  logic                        pop,
    output smf_pkg::t_result            o_result
);

    logic            accept;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    smf_pkg::t_entry q_in;
    smf_pkg::t_entry q_head;

    // a request is taken whenever the queue can hold whatever it might produce
    assign full   = q_full;
    assign accept = push && !q_full;

    smf_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX),
        .MATCH_MAX   (MATCH_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_text_item),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    // requests that give no result never enter the queue
    smf_queue #(
        .DEPTH (smf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // match report first, summary second, one per cycle unless the output stalls
    smf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

/* dv/substring_match_finder_tb.sv */
// Self-checking testbench for the streaming substring match finder.
//
// Text bytes go in as requests on the push/full side. Each accepted request
// is run through a behavioural predictor in this file, and what it predicts
// is queued. A receiver process pops results under random stalls and checks
// each one, field by field, against the oldest prediction.
//
// Order of the run:
//   directed tests: empty pattern straight after reset, zero bytes as data
//   with overlapping matches and the short prefix, an eight-byte pattern
//   with a match on the final byte, an overlong length, the match count
//   limit, and the text length limit;
//   then random texts over four idling phases, several pattern settings in
//   each.
// The pattern is only rewritten once every predicted result has been taken
// and the block has had a few more cycles to drain.
module substring_match_finder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog ceiling, well above the slowest legal run.
    localparam int CYCLE_LIMIT   = 500_000;
    // Drain time before a register write and at the end.
    localparam int SETTLE_CYCLES = 8;
    // Only this many mismatch lines are printed. All of them are counted.
    localparam int REPORT_CAP    = 40;
    // Random bytes sent under each pattern setting.
    localparam int BYTES_PER_SETTING = 64;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [smf_pkg::CFG_A_W-1:0] i_cfg_idx = smf_pkg::CFG_PATTERN_BYTES;
    logic [smf_pkg::CFG_W-1:0]   i_cfg_data = '0;
    logic                        push = 1'b0;
    logic                        full;
    smf_pkg::t_text_item         i_text_item = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    smf_pkg::t_result            o_result;

    substring_match_finder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_text_item (i_text_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Predictor copy of the configuration. Both registers reset to zero.
    logic [smf_pkg::PAT_W-1:0] pat_bytes = '0;
    logic [smf_pkg::LEN_W-1:0] pat_len = '0;

    // Predictor copy of the per-text state.
    logic [55:0]                 seen_bytes = '0;   // newest byte in bits 7:0
    logic [12:0]                 text_pos = '0;     // bytes counted in this text
    logic [smf_pkg::TOTAL_W-1:0] match_count = '0;  // saturates at MATCH_MAX
    logic                        dropped = 1'b0;    // a match or byte was lost

    smf_pkg::t_result pending_results[$];  // predicted, not yet popped
    logic [7:0]       text_buf[$];         // next text to send

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    int mismatches = 0;
    int results_seen = 0;
    int match_reports = 0;
    int summaries = 0;
    int bytes_sent = 0;
    int texts_sent = 0;
    int settings_used = 0;
    int cycle_count = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_CAP) begin
            $display("[%0d] mismatch: %s", cycle_count, msg);
        end
    endtask

    // Works out what one accepted text byte gives: a match report when the
    // newest pattern-length bytes equal the pattern, and a summary when the
    // byte ends the text (match report first if both).
    function automatic void predict_text_byte(input logic [7:0] b, input logic eot);
        logic [63:0]      window;
        smf_pkg::t_result r;
        int               n;
        bit               hit;
        window = {seen_bytes, b};
        n = pat_len;
        if (text_pos >= smf_pkg::TEXT_MAX_DEF) begin
            // past the text limit: ignored, but remembered as a loss
            dropped = 1'b1;
        end else begin
            text_pos = text_pos + 1'b1;
            // empty or overlong length never matches; nor does a match
            // that would start before the first byte of the text
            hit = (n >= 1) && (n <= smf_pkg::PATTERN_MAX_DEF) && (text_pos >= n);
            if (hit) begin
                for (int k = 0; k < n; k++) begin
                    if (window[8*(n-1-k) +: 8] != pat_bytes[8*k +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                if (match_count < smf_pkg::MATCH_MAX_DEF) begin
                    match_count = match_count + 1'b1;
                    r.kind        = smf_pkg::KIND_MATCH;
                    r.match_start = smf_pkg::IDX_W'(text_pos - n);
                    r.match_total = match_count;
                    r.found       = 1'b1;
                    r.truncated   = dropped;
                    r.last        = 1'b0;
                    pending_results.push_back(r);
                end else begin
                    // count already at its ceiling: lost, not reported
                    dropped = 1'b1;
                end
            end
            seen_bytes = window[55:0];
        end
        if (eot) begin
            r.kind        = smf_pkg::KIND_SUMMARY;
            r.match_start = '0;
            r.match_total = match_count;
            r.found       = (match_count != 0);
            r.truncated   = dropped;
            r.last        = 1'b1;
            pending_results.push_back(r);
            seen_bytes  = '0;
            text_pos    = '0;
            match_count = '0;
            dropped     = 1'b0;
        end
    endfunction

    // Offers one request and holds it until taken. Push stays high on
    // return so back-to-back requests run at full rate; it only drops for
    // a random idle gap, before a register write or at the end of the run.
    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_text_item.text_byte   <= b;
        i_text_item.end_of_text <= eot;
        do begin
            @(posedge i_clk);
        end while (full);
        bytes_sent++;
        predict_text_byte(b, eot);
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++) begin
            send_text_byte(text_buf[k], k == text_buf.size() - 1);
        end
        texts_sent++;
    endtask

    // Stops sending, waits for every predicted result, then lets the block
    // drain any requests that carry no result.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive edges. The length write carries
    // whatever the caller puts in the upper bits; only the low nibble counts.
    task automatic set_pattern(input logic [smf_pkg::CFG_W-1:0] bytes_word,
                               input logic [smf_pkg::CFG_W-1:0] len_word);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= smf_pkg::CFG_PATTERN_BYTES;
        i_cfg_data <= bytes_word;
        @(posedge i_clk);
        pat_bytes = bytes_word;
        i_cfg_idx  <= smf_pkg::CFG_PATTERN_LENGTH;
        i_cfg_data <= len_word;
        @(posedge i_clk);
        pat_len = len_word[smf_pkg::LEN_W-1:0];
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Random text biased towards the pattern: whole copies of it spliced
    // in, and loose bytes that are often pattern bytes, so partial matches
    // and overlaps turn up as well as plain noise.
    task automatic fill_random_text(input int n);
        int k;
        text_buf.delete();
        while (text_buf.size() < n) begin
            if ($urandom_range(99) < 15 && pat_len >= 1
                    && pat_len <= smf_pkg::PATTERN_MAX_DEF) begin
                for (int j = 0; j < pat_len; j++) begin
                    text_buf.push_back(pat_bytes[8*j +: 8]);
                end
            end else if ($urandom_range(1) != 0) begin
                k = $urandom_range(7);
                text_buf.push_back(pat_bytes[8*k +: 8]);
            end else begin
                text_buf.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    // Mostly lengths 1..8, now and then empty or overlong. Bytes are either
    // fully random or drawn from two values, which makes overlaps common.
    task automatic random_pattern_setting();
        int          style;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [63:0] bytes_word;
        logic [63:0] len_word;
        style = $urandom_range(9);
        a = 8'($urandom_range(255));
        b = ($urandom_range(3) == 0) ? a : 8'($urandom_range(255));
        for (int k = 0; k < 8; k++) begin
            bytes_word[8*k +: 8] = ($urandom_range(1) != 0) ? a : b;
        end
        if ($urandom_range(2) == 0) begin
            bytes_word = {$urandom, $urandom};
        end
        len_word = {$urandom, $urandom};
        if (style == 0) begin
            len_word[smf_pkg::LEN_W-1:0] = '0;
        end else if (style == 1) begin
            len_word[smf_pkg::LEN_W-1:0] =
                smf_pkg::LEN_W'($urandom_range(15, smf_pkg::PATTERN_MAX_DEF + 1));
        end else begin
            len_word[smf_pkg::LEN_W-1:0] =
                smf_pkg::LEN_W'($urandom_range(smf_pkg::PATTERN_MAX_DEF, 1));
        end
        set_pattern(bytes_word, len_word);
    endtask

    task automatic check_result(input smf_pkg::t_result got);
        smf_pkg::t_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf(
                "result %0d with none expected: kind %0b start %0d total %0d last %0b",
                results_seen, got.kind, got.match_start, got.match_total, got.last));
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind) begin
            report_mismatch($sformatf("result %0d kind got %0b want %0b",
                results_seen, got.kind, want.kind));
        end
        if (got.match_start !== want.match_start) begin
            report_mismatch($sformatf("result %0d match_start got %0d want %0d",
                results_seen, got.match_start, want.match_start));
        end
        if (got.match_total !== want.match_total) begin
            report_mismatch($sformatf("result %0d match_total got %0d want %0d",
                results_seen, got.match_total, want.match_total));
        end
        if (got.found !== want.found) begin
            report_mismatch($sformatf("result %0d found got %0b want %0b",
                results_seen, got.found, want.found));
        end
        if (got.truncated !== want.truncated) begin
            report_mismatch($sformatf("result %0d truncated got %0b want %0b",
                results_seen, got.truncated, want.truncated));
        end
        if (got.last !== want.last) begin
            report_mismatch($sformatf("result %0d last got %0b want %0b",
                results_seen, got.last, want.last));
        end
        if (want.kind == smf_pkg::KIND_MATCH) begin
            match_reports++;
        end else begin
            summaries++;
        end
    endtask

    // Receiver: check whatever is taken at this edge, then pick next
    // cycle's pop under the current stall rate.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            check_result(o_result);
        end
        pop <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL substring_match_finder");
            $finish;
        end
    end

    // Straight after reset the length is zero, and the pattern bytes are
    // zero too, so a text of zero bytes must still not match.
    task automatic test_empty_pattern();
        text_buf = '{8'h00, 8'h00, 8'h00};
        send_text();
    endtask

    // Zero bytes are data. Pattern 00 00: the first byte cannot match even
    // though the cleared window is all zeros; after that every byte
    // matches, overlapping, and the last one gives a match and a summary.
    task automatic test_zero_byte_overlap();
        set_pattern('0, 64'd2);
        text_buf = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_text();
    endtask

    // Full eight-byte pattern, first byte FF. Period-two pattern, so the
    // second hit overlaps the first; it lands on the final byte.
    task automatic test_full_length_pattern();
        set_pattern(64'h00FF_00FF_00FF_00FF, 64'd8);
        text_buf = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                     8'hFF, 8'h00};
        send_text();
    endtask

    // All-ones write to the length register: low nibble 15, above the
    // pattern maximum, so the same text gives no match.
    task automatic test_overlong_length();
        set_pattern(64'h00FF_00FF_00FF_00FF, '1);
        text_buf = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        send_text();
    endtask

    // One-byte pattern and a long run of it: the count stops at its
    // ceiling and the rest are lost. A following one-byte text checks that
    // the count and the loss flag were cleared by the end of text.
    task automatic test_match_limit();
        sender_idle_pct = 17;
        receiver_stall_pct = 17;
        set_pattern(64'hA5A5_A5A5_A5A5_A541, 64'd1);
        text_buf.delete();
        repeat (smf_pkg::MATCH_MAX_DEF + 3) text_buf.push_back(8'h41);
        send_text();
        text_buf = '{8'h41};
        send_text();
    endtask

    // A text longer than the limit. A match ends one byte before the limit,
    // the byte that would complete the next match is past the limit, and
    // the end of text itself is on an ignored byte.
    task automatic test_text_limit();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        set_pattern(64'h0000_0000_0000_A55A, 64'd2);
        text_buf.delete();
        while (text_buf.size() < smf_pkg::TEXT_MAX_DEF - 3) begin
            if ($urandom_range(99) == 0) begin
                text_buf.push_back(8'h5A);
                text_buf.push_back(8'hA5);
            end else begin
                text_buf.push_back(8'($urandom_range(255)));
            end
        end
        while (text_buf.size() > smf_pkg::TEXT_MAX_DEF - 3) begin
            void'(text_buf.pop_back());
        end
        text_buf.push_back(8'h5A);
        text_buf.push_back(8'hA5);
        text_buf.push_back(8'h5A);
        text_buf.push_back(8'hA5);
        text_buf.push_back(8'h00);
        text_buf.push_back(8'h5A);
        send_text();
    endtask

    // One idling phase of random texts under four pattern settings.
    task automatic test_random_texts(input int send_pct, input int recv_pct);
        int n;
        int budget;
        sender_idle_pct = send_pct;
        receiver_stall_pct = recv_pct;
        repeat (4) begin
            random_pattern_setting();
            budget = 0;
            while (budget < BYTES_PER_SETTING) begin
                if ($urandom_range(9) == 0) begin
                    n = $urandom_range(120, 25);
                end else begin
                    n = $urandom_range(24, 1);
                end
                fill_random_text(n);
                budget += text_buf.size();
                send_text();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pattern();
        test_zero_byte_overlap();
        test_full_length_pattern();
        test_overlong_length();
        test_match_limit();
        test_text_limit();

        test_random_texts(0, 0);
        test_random_texts(51, 0);
        test_random_texts(0, 51);
        test_random_texts(17, 17);

        wait_idle();

        $display("Sent %0d text bytes in %0d texts under %0d pattern settings",
                 bytes_sent, texts_sent, settings_used);
        $display("Checked %0d match reports and %0d summaries, %0d mismatches",
                 match_reports, summaries, mismatches);
        if (mismatches == 0) begin
            $display("PASS substring_match_finder");
        end else begin
            $display("FAIL substring_match_finder");
        end
        $finish;
    end

endmodule
